// File: rtl/elp_pkg.sv
package elp_pkg;

   // Field widths.
   localparam int EchoW    = 15;
   localparam int DistW    = 18;
   localparam int AreaW    = 16;
   localparam int VolW     = 24;

   // Configuration port.
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 24;

   localparam logic [CsrIdxW-1:0] REG_EMPTY_HEIGHT   = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_FULL_HEIGHT    = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_BASE_AREA      = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_MAX_VOLUME     = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_FAULT_DISTANCE = 3'd4;

   localparam logic [DistW-1:0] RstEmptyHeight   = 18'd25600;
   localparam logic [DistW-1:0] RstFullHeight    = 18'd1280;
   localparam logic [AreaW-1:0] RstBaseArea      = 16'd256;
   localparam logic [VolW-1:0]  RstMaxVolume     = 24'd25600;
   localparam logic [DistW-1:0] RstFaultDistance = 18'd4608;

   // Half the speed of sound, 0.0343 cm/us / 2, in Q8 of 1/256 cm per us.
   localparam int SoundQ8W = 11;
   localparam logic [SoundQ8W-1:0] SoundQ8 = 11'd1124;

   localparam int DefaultSamples = 8;

endpackage

// File: rtl/elp_channels.sv
interface elp_req_if import elp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [EchoW-1:0] echo_time;

   modport source (output valid, output echo_time, input ready);
   modport sink   (input valid, input echo_time, output ready);
endinterface

interface elp_rsp_if import elp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [DistW-1:0] avg_distance;
   logic [VolW-1:0]  volume;

   modport source (output valid, output avg_distance, output volume, input ready);
   modport sink   (input valid, input avg_distance, input volume, output ready);
endinterface

interface elp_csr_if import elp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  reg_index;
   logic [CsrDataW-1:0] data;

   modport source (output valid, output reg_index, output data, input ready);
   modport sink   (input valid, input reg_index, input data, output ready);
endinterface

// File: rtl/echo_level_averager_core.sv
// Ultrasonic tank level averager. Each request word carries one echo width in
// microseconds; it is turned into a distance in 1/256 cm (a zero width uses
// the fault distance register), averaged over the last SAMPLES distances and
// answered with one response word holding the average distance and the liquid
// volume. The sample ring lives in a one-port-read, one-port-write memory and
// the first sample after reset stands in for entries not yet written, so the
// average is valid from the first word on. One word is processed at a time.
// The ring is read at the edge that accepts the request. The response is
// presented after ring update and running sum, reciprocal multiply, quotient
// correction, volume multiply and output load. The output load waits while
// the response register still holds a previous word not yet taken. The next
// request can be accepted only once the output load is done and the block is
// idle again. A new request is accepted while an earlier response is still
// pending. Configuration writes are accepted in every cycle and take effect
// at once.
module echo_level_averager_core
   import elp_pkg::*;
#(
   parameter int SAMPLES = DefaultSamples
) (
   input  logic       clock,
   input  logic       reset,
   elp_req_if.sink    req_ch,
   elp_rsp_if.source  rsp_ch,
   elp_csr_if.sink    csr_ch
);

   localparam int IdxW = $clog2(SAMPLES);
   localparam int SumW = DistW + $clog2(SAMPLES);
   localparam int ProdW = 2 * SumW;
   // floor(2^SumW / SAMPLES); the quotient it gives is at most one too small.
   localparam logic [SumW-1:0] Recip = SumW'((longint'(1) << SumW) / SAMPLES);
   localparam logic [SumW-1:0] SamplesW = SumW'(SAMPLES);
   localparam logic [IdxW-1:0] LastSlot = IdxW'(SAMPLES - 1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SUM     = 3'd1;
   localparam logic [2:0] ST_DIV_MUL = 3'd2;
   localparam logic [2:0] ST_DIV_FIX = 3'd3;
   localparam logic [2:0] ST_VOL_MUL = 3'd4;
   localparam logic [2:0] ST_OUT     = 3'd5;

   logic [2:0]              state_ff;
   logic [2:0]              state_in;

   logic [DistW-1:0]        empty_ff;
   logic [DistW-1:0]        full_ff;
   logic [AreaW-1:0]        area_ff;
   logic [VolW-1:0]         maxvol_ff;
   logic [DistW-1:0]        fault_ff;

   logic [DistW-1:0]        ring_mem [SAMPLES];
   logic [DistW-1:0]        rd_ff;
   logic [SAMPLES-1:0]      written_ff;
   logic [IdxW-1:0]         slot_ff;
   logic [DistW-1:0]        first_ff;
   logic                    warm_ff;
   logic [SumW-1:0]         sum_ff;
   logic [SumW-1:0]         sum_in;

   logic [DistW-1:0]        dist_ff;
   logic [DistW-1:0]        dist_in;
   logic [ProdW-1:0]        prod_ff;
   logic [DistW-1:0]        avg_ff;
   logic [DistW-1:0]        avg_in;
   logic [DistW+AreaW-1:0]  vprod_ff;
   logic                    is_empty_ff;
   logic                    is_full_ff;

   logic                    rsp_valid_ff;
   logic [DistW-1:0]        rsp_avg_ff;
   logic [VolW-1:0]         rsp_vol_ff;

   logic                    req_take;
   logic                    out_load;
   logic [DistW-1:0]        old_dist;
   logic [SumW-1:0]         quot0;
   logic [SumW-1:0]         rem0;
   logic [DistW+AreaW-9:0]  vol_shift;
   logic [VolW-1:0]         vol_in;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign out_load     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ch.ready);

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.avg_distance = rsp_avg_ff;
   assign rsp_ch.volume       = rsp_vol_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_take) state_in = ST_SUM;
         ST_SUM:     state_in = ST_DIV_MUL;
         ST_DIV_MUL: state_in = ST_DIV_FIX;
         ST_DIV_FIX: state_in = ST_VOL_MUL;
         ST_VOL_MUL: state_in = ST_OUT;
         ST_OUT:     if (out_load) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Distance conversion; the product of a 15-bit width and 1124 keeps 18 bits.
   always_comb begin
      dist_in = DistW'((EchoW+SoundQ8W)'(req_ch.echo_time) * (EchoW+SoundQ8W)'(SoundQ8)
                       >> 8);
      if (req_ch.echo_time == '0) begin
         dist_in = fault_ff;
      end
   end

   // Before warm-up every entry counts as this first distance.
   always_comb begin
      old_dist = written_ff[slot_ff] ? rd_ff : first_ff;
      if (warm_ff) begin
         sum_in = sum_ff - SumW'(old_dist) + SumW'(dist_ff);
      end else begin
         sum_in = SumW'(SumW'(dist_ff) * SamplesW);
      end
   end

   always_comb begin
      quot0  = prod_ff[ProdW-1:SumW];
      rem0   = sum_ff - SumW'(quot0 * SamplesW);
      avg_in = (rem0 >= SamplesW) ? DistW'(quot0 + SumW'(1)) : DistW'(quot0);
   end

   always_comb begin
      vol_shift = vprod_ff[DistW+AreaW-1:8];
      if (is_empty_ff) begin
         vol_in = '0;
      end else if (is_full_ff) begin
         vol_in = maxvol_ff;
      end else if (vol_shift[DistW+AreaW-9:VolW] != '0) begin
         vol_in = '1;
      end else begin
         vol_in = vol_shift[VolW-1:0];
      end
   end

   // Ring memory: read when a word is taken, written back in the next cycle, in the sum state.
   always_ff @(posedge clock) begin
      if (req_take) begin
         rd_ff <= ring_mem[slot_ff];
      end
      if (state_ff == ST_SUM) begin
         ring_mem[slot_ff] <= dist_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         written_ff   <= '0;
         slot_ff      <= '0;
         first_ff     <= '0;
         warm_ff      <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_SUM) begin
            sum_ff              <= sum_in;
            written_ff[slot_ff] <= 1'b1;
            slot_ff             <= (slot_ff == LastSlot) ? '0 : slot_ff + IdxW'(1);
            warm_ff             <= 1'b1;
            if (!warm_ff) begin
               first_ff <= dist_ff;
            end
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         dist_ff <= dist_in;
      end
      if (state_ff == ST_DIV_MUL) begin
         prod_ff <= ProdW'(sum_ff) * ProdW'(Recip);
      end
      if (state_ff == ST_DIV_FIX) begin
         avg_ff <= avg_in;
      end
      if (state_ff == ST_VOL_MUL) begin
         vprod_ff    <= (DistW+AreaW)'(empty_ff - avg_ff) * (DistW+AreaW)'(area_ff);
         is_empty_ff <= (avg_ff >= empty_ff);
         is_full_ff  <= (avg_ff <= full_ff);
      end
      if (out_load) begin
         rsp_avg_ff <= avg_ff;
         rsp_vol_ff <= vol_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff  <= RstEmptyHeight;
         full_ff   <= RstFullHeight;
         area_ff   <= RstBaseArea;
         maxvol_ff <= RstMaxVolume;
         fault_ff  <= RstFaultDistance;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.reg_index)
            REG_EMPTY_HEIGHT:   empty_ff  <= csr_ch.data[DistW-1:0];
            REG_FULL_HEIGHT:    full_ff   <= csr_ch.data[DistW-1:0];
            REG_BASE_AREA:      area_ff   <= csr_ch.data[AreaW-1:0];
            REG_MAX_VOLUME:     maxvol_ff <= csr_ch.data[VolW-1:0];
            REG_FAULT_DISTANCE: fault_ff  <= csr_ch.data[DistW-1:0];
            default: ;
         endcase
      end
   end

endmodule

// File: rtl/elp_checker.sv
module elp_checker
   import elp_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [DistW-1:0] avg_distance,
   input logic [VolW-1:0]  volume
);

   logic [1:0] outstanding_ff;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // Words accepted whose response has not been taken yet.
   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_ff + 2'(req_take) - 2'(rsp_take);
      end
   end

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 2'd0)
      else $error("response without an accepted request");

   a_outstanding_bound: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= 2'd2)
      else $error("more than two words in flight");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ready)
      else $error("request accepted on back-to-back cycles");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(avg_distance) && $stable(volume))
      else $error("stalled response changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind echo_level_averager_core elp_checker u_elp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .avg_distance (rsp_ch.avg_distance),
   .volume       (rsp_ch.volume)
);
